// ===== design/fkvc_pkg.sv =====
// Shared types and constants for the FIFO-replacement key-value cache.
`default_nettype none
package fkvc_pkg;

    // Fixed widths of the capacity register and the response fields
    localparam int CAP_BITS = 5;
    localparam int OUT_BITS = 32;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd3;

    // Request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Response status codes
    typedef enum logic [2:0] {
        ST_GET_HIT  = 3'd0,
        ST_GET_MISS = 3'd1,
        ST_PUT_UPD  = 3'd2,
        ST_PUT_FILL = 3'd3,
        ST_PUT_EVICT = 3'd4
    } t_status;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic shift;   // put of a new key: every cell takes its neighbor's entry, cell 0 the new one
        logic update;  // put of a present key: the hitting cell takes the new value
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== design/fkvc_req_if.sv =====
// Request channel: operation, key and value with valid/ready.
`default_nettype none
interface fkvc_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;

    modport source (output valid, op, lookup_key, write_value, input ready);
    modport sink   (input valid, op, lookup_key, write_value, output ready);
endinterface
`default_nettype wire

// ===== design/fkvc_rsp_if.sv =====
// Response channel: status, read value and evicted key with valid/ready.
`default_nettype none
interface fkvc_rsp_if;
    logic                          valid;
    logic                          ready;
    fkvc_pkg::t_status             status;
    logic [fkvc_pkg::OUT_BITS-1:0] read_value;
    logic [fkvc_pkg::OUT_BITS-1:0] evicted_key;

    modport source (output valid, status, read_value, evicted_key, input ready);
    modport sink   (input valid, status, read_value, evicted_key, output ready);
endinterface
`default_nettype wire

// ===== design/fkvc_cell.sv =====
// One cache cell: holds one entry, compares it and passes it to the next cell.
`default_nettype none
module fkvc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int FILL_BITS  = 5,
    parameter int IDX        = 0
) (
    input  wire                        i_clk,
    input  wire fkvc_pkg::t_cell_ctl   i_ctl,
    input  wire  [FILL_BITS-1:0]       i_fill,
    input  wire  [KEY_BITS-1:0]        i_lookup_key,
    input  wire  [VALUE_BITS-1:0]      i_write_value,
    input  wire  [KEY_BITS-1:0]        i_prev_key,
    input  wire  [VALUE_BITS-1:0]      i_prev_value,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [VALUE_BITS-1:0]      o_value,
    output logic                       o_hit,
    output logic                       o_last
);
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  w_valid;

    // Cells below the fill count hold live entries, newest in cell 0
    assign w_valid = FILL_BITS'(IDX) < i_fill;
    assign o_hit   = w_valid && (r_key == i_lookup_key);
    assign o_last  = w_valid && (FILL_BITS'(IDX + 1) == i_fill);
    assign o_key   = r_key;
    assign o_value = r_value;

    // Shift on a new insert, overwrite the value on an update hit
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end else if (i_ctl.update && o_hit) begin
            r_value <= i_write_value;
        end
    end
endmodule
`default_nettype wire

// ===== design/fifo_replacement_kv_cache_unit.sv =====
// Top level: FIFO-replacement key-value cache built as a shifting row of cells.
//
//  channel  dir  handshake          payload
//  i_req    in   valid/ready        op, lookup_key, write_value
//  o_rsp    out  valid/ready        status, read_value, evicted_key
//  cfg      in   i_cfg_we           i_cfg_wdata (capacity_in_use)
//
// One request per cycle while responses drain: every cell compares its key in parallel
// and the response is registered in the same cycle the request is accepted.
// A new request is taken while the response register is empty or being drained.
// Reset clears the fill count, the response valid and sets capacity to 3;
// cell contents are not reset. A stalled response holds and blocks new requests.
`default_nettype none
module fifo_replacement_kv_cache_unit #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [fkvc_pkg::CAP_BITS-1:0]     i_cfg_wdata,
    fkvc_req_if.sink                          i_req,
    fkvc_rsp_if.source                        o_rsp
);
    localparam int FW  = $clog2(ENTRIES + 1);
    localparam int CW  = (FW > fkvc_pkg::CAP_BITS) ? FW : fkvc_pkg::CAP_BITS;
    localparam int OB  = fkvc_pkg::OUT_BITS;

    logic [fkvc_pkg::CAP_BITS-1:0] r_cap;
    logic [FW-1:0]                 r_fill, n_fill;
    logic                          r_rsp_valid;
    fkvc_pkg::t_status             r_status, n_status;
    logic [OB-1:0]                 r_rd, n_rd, r_ev, n_ev;

    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [VALUE_BITS-1:0] w_value [ENTRIES];
    logic [ENTRIES-1:0]    w_hit, w_last;
    fkvc_pkg::t_cell_ctl   w_ctl;

    logic                  w_accept, w_any_hit, w_evict;
    logic [CW-1:0]         w_cap_eff;
    logic [VALUE_BITS-1:0] w_hit_value;
    logic [KEY_BITS-1:0]   w_old_key;

    // Request flow: accept when the response register is free
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Row of cells, cell 0 takes the incoming key on a shift
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_pk;
        logic [VALUE_BITS-1:0] w_pv;
        if (g == 0) begin : g_head
            assign w_pk = i_req.lookup_key;
            assign w_pv = i_req.write_value;
        end else begin : g_body
            assign w_pk = w_key[g-1];
            assign w_pv = w_value[g-1];
        end
        fkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .FILL_BITS  (FW),
            .IDX        (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_fill        (r_fill),
            .i_lookup_key  (i_req.lookup_key),
            .i_write_value (i_req.write_value),
            .i_prev_key    (w_pk),
            .i_prev_value  (w_pv),
            .o_key         (w_key[g]),
            .o_value       (w_value[g]),
            .o_hit         (w_hit[g]),
            .o_last        (w_last[g])
        );
    end

    // One-hot selection of the hitting value and the oldest key
    always_comb begin
        w_hit_value = '0;
        w_old_key   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_value = w_hit_value | (w_value[i] & {VALUE_BITS{w_hit[i]}});
            w_old_key   = w_old_key   | (w_key[i]   & {KEY_BITS{w_last[i]}});
        end
    end

    // Effective capacity: at least one, at most the number of cells
    always_comb begin
        w_cap_eff = CW'(r_cap);
        if (r_cap == '0) begin
            w_cap_eff = CW'(1);
        end
        if (w_cap_eff > CW'(ENTRIES)) begin
            w_cap_eff = CW'(ENTRIES);
        end
    end

    assign w_any_hit = |w_hit;
    assign w_evict   = CW'(r_fill) >= w_cap_eff;

    assign w_ctl.shift  = w_accept && (i_req.op == fkvc_pkg::OP_PUT) && !w_any_hit;
    assign w_ctl.update = w_accept && (i_req.op == fkvc_pkg::OP_PUT) && w_any_hit;

    // Response and fill count next values
    always_comb begin
        logic [OB+VALUE_BITS-1:0] v_rd_ext;
        logic [OB+KEY_BITS-1:0]   v_ev_ext;
        v_rd_ext = {{OB{1'b0}}, w_hit_value};
        v_ev_ext = {{OB{1'b0}}, w_old_key};
        n_fill   = r_fill;
        n_rd     = '0;
        n_ev     = '0;
        if (i_req.op == fkvc_pkg::OP_GET) begin
            if (w_any_hit) begin
                n_status = fkvc_pkg::ST_GET_HIT;
                n_rd     = v_rd_ext[OB-1:0];
            end else begin
                n_status = fkvc_pkg::ST_GET_MISS;
            end
        end else if (w_any_hit) begin
            n_status = fkvc_pkg::ST_PUT_UPD;
        end else if (w_evict) begin
            n_status = fkvc_pkg::ST_PUT_EVICT;
            n_ev     = v_ev_ext[OB-1:0];
        end else begin
            n_status = fkvc_pkg::ST_PUT_FILL;
            n_fill   = r_fill + FW'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= fkvc_pkg::CAP_RESET;
            r_fill      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_fill      <= n_fill;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_ev     <= n_ev;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_value  = r_rd;
    assign o_rsp.evicted_key = r_ev;

`ifndef SYNTHESIS
    // Live keys are unique, so at most one cell hits
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell hit");

    // Fill count never passes the number of cells
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(ENTRIES))
        else $error("fill count out of range");

    // A free-slot fill grows the count by one
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.shift && !w_evict) |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("fill count did not grow on a fill");

    // An eviction keeps the count and needs an oldest entry
    a_evict_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.shift && w_evict) |-> ($onehot(w_last)) ##1 $stable(r_fill))
        else $error("eviction without a single oldest entry");
`endif
endmodule
`default_nettype wire
